// ----- design/ils_pkg.sv -----
// ils_pkg: shared types, limits and the base-60 fold for the integer literal scanner
// no dependencies; imported by ils_parse, integer_literal_scanner_unit and the testbench
package ils_pkg;

    localparam logic [63:0] MAG_LIMIT   = 64'h8000_0000_0000_0000;
    localparam logic [69:0] MAG_LIMIT_W = {6'd0, MAG_LIMIT};

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGN,
        PH_ZERO,
        PH_BODY,
        PH_WAIT
    } t_phase;

    typedef enum logic [1:0] {
        RC_DEC,
        RC_HEX,
        RC_OCT,
        RC_BIN
    } t_radix;

    // parser state at the final beat of a scalar
    typedef struct packed {
        logic        negative;
        logic        colon_seen;
        logic        too_long;
        logic        radix_err;
        logic [63:0] radix_mag;
        logic        sexa_fail;
        logic        group_has_digit;
        logic [63:0] sexa_total;
        logic [63:0] sexa_group;
    } t_snap;

    // total * 60 + group, wide enough that nothing is lost
    function automatic logic [69:0] ils_fold(input logic [63:0] total,
                                             input logic [63:0] group);
        logic [69:0] t;
        t = {6'd0, total};
        return (t << 6) - (t << 2) + {6'd0, group};
    endfunction

endpackage

// ----- design/ils_parse.sv -----
// ils_parse: per-character parser state (prefix, radix and base-60 readings)
// depends on ils_pkg; hands the final state of each scalar to the top level
module ils_parse #(
    parameter int MAX_CHARS = 79
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [7:0]    i_char,
    input  logic          i_last,
    output ils_pkg::t_snap o_snap
);
    import ils_pkg::*;

    localparam int CNT_W = $clog2(MAX_CHARS + 2);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHARS);

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_ONE        = 8'h31;
    localparam logic [7:0] CH_SEVEN      = 8'h37;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_LO_A       = 8'h61;
    localparam logic [7:0] CH_LO_F       = 8'h66;
    localparam logic [7:0] CH_UP_A       = 8'h41;
    localparam logic [7:0] CH_UP_F       = 8'h46;
    localparam logic [7:0] CH_LO_X       = 8'h78;
    localparam logic [7:0] CH_UP_X       = 8'h58;
    localparam logic [7:0] CH_LO_B       = 8'h62;
    localparam logic [7:0] CH_UP_B       = 8'h42;
    localparam logic [7:0] CH_LO_O       = 8'h6F;

    t_phase           r_phase, n_phase;
    logic             r_neg, n_neg;
    t_radix           r_radix, n_radix;
    logic [63:0]      r_mag, n_mag;
    logic             r_rfail, n_rfail;
    logic [63:0]      r_total, n_total;
    logic [63:0]      r_group, n_group;
    logic [1:0]       r_done, n_done;
    logic             r_ghd, n_ghd;
    logic             r_sfail, n_sfail;
    logic             r_colon, n_colon;
    logic [CNT_W-1:0] r_count, n_count;

    logic        w_kept;
    logic        w_dec_ok;
    logic        w_hex_ok;
    logic [3:0]  w_hex_val;
    t_radix      w_rc_eff;
    logic        w_dig_ok;
    logic [67:0] w_mag_w;
    logic [67:0] w_prod;
    logic        w_rad_ovf;
    logic        w_rf_fail;
    logic [63:0] w_rf_mag;
    logic [67:0] w_g10;
    logic [69:0] w_fold;
    logic        w_sf_fail;
    logic [63:0] w_sf_total;
    logic [63:0] w_sf_group;
    logic [1:0]  w_sf_done;
    logic        w_sf_ghd;

    // digit decode
    always_comb begin
        w_dec_ok  = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        w_hex_ok  = 1'b0;
        w_hex_val = 4'd0;
        if (w_dec_ok) begin
            w_hex_ok  = 1'b1;
            w_hex_val = i_char[3:0];
        end else if (((i_char >= CH_LO_A) && (i_char <= CH_LO_F)) ||
                     ((i_char >= CH_UP_A) && (i_char <= CH_UP_F))) begin
            w_hex_ok  = 1'b1;
            w_hex_val = i_char[3:0] + 4'd9;
        end
    end

    // radix reading
    always_comb begin
        w_rc_eff = (r_phase == PH_ZERO) ? RC_OCT : r_radix;
        w_mag_w  = {4'd0, r_mag};
        unique case (w_rc_eff)
            RC_HEX: begin
                w_dig_ok = w_hex_ok;
                w_prod   = w_mag_w << 4;
            end
            RC_OCT: begin
                w_dig_ok = (i_char >= CH_ZERO) && (i_char <= CH_SEVEN);
                w_prod   = w_mag_w << 3;
            end
            RC_BIN: begin
                w_dig_ok = (i_char == CH_ZERO) || (i_char == CH_ONE);
                w_prod   = w_mag_w << 1;
            end
            default: begin
                w_dig_ok = w_dec_ok;
                w_prod   = (w_mag_w << 3) + (w_mag_w << 1);
            end
        endcase
        w_prod    = w_prod + {64'd0, w_hex_val};
        w_rad_ovf = w_prod > {4'd0, MAG_LIMIT};
        w_rf_fail = r_rfail || !w_dig_ok || w_rad_ovf;
        w_rf_mag  = (w_dig_ok && !r_rfail && !w_rad_ovf) ? w_prod[63:0] : r_mag;
    end

    // base-60 reading
    always_comb begin
        w_g10      = ({4'd0, r_group} << 3) + ({4'd0, r_group} << 1)
                     + {64'd0, i_char[3:0]};
        w_fold     = ils_fold(r_total, r_group);
        w_sf_fail  = r_sfail;
        w_sf_total = r_total;
        w_sf_group = r_group;
        w_sf_done  = r_done;
        w_sf_ghd   = r_ghd;
        if (!r_sfail) begin
            if (i_char == CH_COLON) begin
                if (r_done[1] || ((r_done != 2'd0) && !r_ghd) || (w_fold > MAG_LIMIT_W)) begin
                    w_sf_fail = 1'b1;
                end else begin
                    w_sf_total = w_fold[63:0];
                    w_sf_group = 64'd0;
                    w_sf_ghd   = 1'b0;
                    w_sf_done  = r_done + 2'd1;
                end
            end else if (w_dec_ok) begin
                if (w_g10 > {4'd0, MAG_LIMIT}) begin
                    w_sf_fail = 1'b1;
                end else begin
                    w_sf_group = w_g10[63:0];
                    w_sf_ghd   = 1'b1;
                end
            end else begin
                w_sf_fail = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        w_kept  = (i_char != CH_UNDERSCORE) && (i_char != CH_COMMA);
        n_phase = r_phase;
        n_neg   = r_neg;
        n_radix = r_radix;
        n_mag   = r_mag;
        n_rfail = r_rfail;
        n_total = r_total;
        n_group = r_group;
        n_done  = r_done;
        n_ghd   = r_ghd;
        n_sfail = r_sfail;
        n_colon = r_colon;
        n_count = r_count;
        if (w_kept) begin
            if (r_count <= CNT_MAX) begin
                n_count = r_count + 1'b1;
            end
            if (i_char == CH_COLON) begin
                n_colon = 1'b1;
            end
            unique case (r_phase)
                PH_START, PH_SIGN: begin
                    if ((r_phase == PH_START) && (i_char == CH_MINUS)) begin
                        n_neg   = 1'b1;
                        n_phase = PH_SIGN;
                    end else if ((r_phase == PH_START) && (i_char == CH_PLUS)) begin
                        n_phase = PH_SIGN;
                    end else if (i_char == CH_ZERO) begin
                        n_phase = PH_ZERO;
                        n_sfail = w_sf_fail;
                        n_total = w_sf_total;
                        n_group = w_sf_group;
                        n_done  = w_sf_done;
                        n_ghd   = w_sf_ghd;
                    end else begin
                        n_phase = PH_BODY;
                        n_rfail = w_rf_fail;
                        n_mag   = w_rf_mag;
                        n_sfail = w_sf_fail;
                        n_total = w_sf_total;
                        n_group = w_sf_group;
                        n_done  = w_sf_done;
                        n_ghd   = w_sf_ghd;
                    end
                end
                PH_ZERO: begin
                    if ((i_char == CH_LO_X) || (i_char == CH_UP_X)) begin
                        n_radix = RC_HEX;
                        n_phase = PH_WAIT;
                        n_sfail = 1'b1;
                    end else if ((i_char == CH_LO_B) || (i_char == CH_UP_B)) begin
                        n_radix = RC_BIN;
                        n_phase = PH_WAIT;
                        n_sfail = 1'b1;
                    end else if (i_char == CH_LO_O) begin
                        n_radix = RC_OCT;
                        n_phase = PH_BODY;
                    end else begin
                        n_radix = RC_OCT;
                        n_phase = PH_BODY;
                        n_rfail = w_rf_fail;
                        n_mag   = w_rf_mag;
                        n_sfail = w_sf_fail;
                        n_total = w_sf_total;
                        n_group = w_sf_group;
                        n_done  = w_sf_done;
                        n_ghd   = w_sf_ghd;
                    end
                end
                default: begin
                    if ((r_phase == PH_WAIT) && w_dig_ok) begin
                        n_phase = PH_BODY;
                    end
                    n_rfail = w_rf_fail;
                    n_mag   = w_rf_mag;
                    n_sfail = w_sf_fail;
                    n_total = w_sf_total;
                    n_group = w_sf_group;
                    n_done  = w_sf_done;
                    n_ghd   = w_sf_ghd;
                end
            endcase
        end
    end

    always_comb begin
        o_snap.negative        = n_neg;
        o_snap.colon_seen      = n_colon;
        o_snap.too_long        = n_count > CNT_MAX;
        o_snap.radix_err       = n_rfail || !((n_phase == PH_ZERO) || (n_phase == PH_BODY));
        o_snap.radix_mag       = n_mag;
        o_snap.sexa_fail       = n_sfail;
        o_snap.group_has_digit = n_ghd;
        o_snap.sexa_total      = n_total;
        o_snap.sexa_group      = n_group;
    end

    // back to start of scalar on reset and after the final beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_phase <= PH_START;
            r_neg   <= 1'b0;
            r_radix <= RC_DEC;
            r_mag   <= 64'd0;
            r_rfail <= 1'b0;
            r_total <= 64'd0;
            r_group <= 64'd0;
            r_done  <= 2'd0;
            r_ghd   <= 1'b0;
            r_sfail <= 1'b0;
            r_colon <= 1'b0;
            r_count <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_radix <= n_radix;
            r_mag   <= n_mag;
            r_rfail <= n_rfail;
            r_total <= n_total;
            r_group <= n_group;
            r_done  <= n_done;
            r_ghd   <= n_ghd;
            r_sfail <= n_sfail;
            r_colon <= n_colon;
            r_count <= n_count;
        end
    end

endmodule

// ----- design/integer_literal_scanner_unit.sv -----
// integer_literal_scanner_unit: top level, input register, parser and result pipeline
// depends on ils_pkg and ils_parse
//
// Takes one character beat per clock while o_stall is low and, on the beat marked last,
// returns one signed 64-bit value with an error flag; the value is zero when the error
// flag is set. Beats flow back to back at one per cycle unless o_stall is raised; the
// parser state register updates on every accepted beat. After the input register, a
// result passes the parser update, then the base-60 fold and source select, then the
// range check and sign, each registered. Each stage holds only while the stage
// after it is full and stalled, so input keeps flowing while a result waits.
module integer_literal_scanner_unit #(
    parameter int MAX_CHARS = 79
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_char_in,
    input  logic               i_is_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [63:0] o_value,
    output logic               o_error
);
    import ils_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_last;

    logic        r_s1_valid;
    t_snap       r_s1_snap;

    logic        r_s2_valid;
    logic [63:0] r_s2_mag;
    logic        r_s2_err;
    logic        r_s2_neg;

    logic               r_out_valid;
    logic signed [63:0] r_out_value;
    logic               r_out_error;

    logic        w_rdy_out;
    logic        w_rdy_s2;
    logic        w_rdy_s1;
    logic        w_rdy_in;
    logic        w_en;
    t_snap       w_snap;

    logic [69:0] w_fold;
    logic [63:0] n_s2_mag;
    logic        n_s2_err;
    logic [63:0] w_limit;
    logic        n_out_err;
    logic [63:0] n_out_value;

    assign w_rdy_out = !r_out_valid || !i_stall;
    assign w_rdy_s2  = !r_s2_valid || w_rdy_out;
    assign w_rdy_s1  = !r_s1_valid || w_rdy_s2;
    assign w_rdy_in  = !r_in_valid || !r_in_last || w_rdy_s1;
    assign w_en      = r_in_valid && w_rdy_in;
    assign o_stall   = !w_rdy_in;

    ils_parse #(
        .MAX_CHARS(MAX_CHARS)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .o_snap  (w_snap)
    );

    // fold and pick the reading
    always_comb begin
        w_fold = ils_fold(r_s1_snap.sexa_total, r_s1_snap.sexa_group);
        if (r_s1_snap.colon_seen) begin
            n_s2_mag = w_fold[63:0];
            n_s2_err = r_s1_snap.sexa_fail || !r_s1_snap.group_has_digit
                       || (w_fold > MAG_LIMIT_W);
        end else begin
            n_s2_mag = r_s1_snap.radix_mag;
            n_s2_err = r_s1_snap.radix_err;
        end
        n_s2_err = n_s2_err || r_s1_snap.too_long;
    end

    // range check and sign
    always_comb begin
        w_limit   = r_s2_neg ? MAG_LIMIT : MAG_LIMIT - 64'd1;
        n_out_err = r_s2_err || (r_s2_mag > w_limit);
        if (n_out_err) begin
            n_out_value = 64'd0;
        end else if (r_s2_neg) begin
            n_out_value = 64'd0 - r_s2_mag;
        end else begin
            n_out_value = r_s2_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy_in) begin
                r_in_valid <= i_valid;
            end
            if (w_rdy_s1) begin
                r_s1_valid <= w_en && r_in_last;
            end
            if (w_rdy_s2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_rdy_out) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_in) begin
            r_in_char <= i_char_in;
            r_in_last <= i_is_last;
        end
        if (w_rdy_s1) begin
            r_s1_snap <= w_snap;
        end
        if (w_rdy_s2) begin
            r_s2_mag <= n_s2_mag;
            r_s2_err <= n_s2_err;
            r_s2_neg <= r_s1_snap.negative;
        end
        if (w_rdy_out) begin
            r_out_value <= n_out_value;
            r_out_error <= n_out_err;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_error = r_out_error;

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_error |-> r_out_value == 64'sd0)
        else $error("error beat with nonzero value");

    a_snap_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !$past(r_s1_valid) |-> $past(r_in_valid && r_in_last))
        else $error("result stage loaded without a last beat");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_in_last && r_s1_valid && r_s2_valid
                    && r_out_valid && i_stall)
        else $error("input stalled with room in the pipeline");

endmodule

// ----- verif/integer_literal_scanner_unit_tb.sv -----
// integer_literal_scanner_unit_tb: feeds scalar text beats to the scanner, tracks the parser
// state in a scoreboard and checks every value and error flag it returns
// depends on ils_pkg and integer_literal_scanner_unit
module integer_literal_scanner_unit_tb;

    import ils_pkg::*;

    localparam int SCAN_MAX_CHARS = 79;
    localparam int BEAT_TARGET    = 650;
    localparam int IDLE_PCT       = 19;

    typedef struct {
        logic signed [63:0] value;
        logic               error;
    } t_scalar_result;

    class scalar_scoreboard;
        t_phase         phase;
        t_radix         radix;
        bit             neg;
        bit [63:0]      rmag;
        bit             rfail;
        bit [63:0]      stotal;
        bit [63:0]      sgroup;
        bit [1:0]       sdone;
        bit             gdigit;
        bit             sfail;
        bit             colon;
        int unsigned    kept;
        t_scalar_result parsed_q[$];
        int unsigned    errors;

        function new();
            clear_scalar();
            errors = 0;
        endfunction

        function void clear_scalar();
            phase  = PH_START;
            radix  = RC_DEC;
            neg    = 1'b0;
            rmag   = '0;
            rfail  = 1'b0;
            stotal = '0;
            sgroup = '0;
            sdone  = '0;
            gdigit = 1'b0;
            sfail  = 1'b0;
            colon  = 1'b0;
            kept   = 0;
        endfunction

        function bit [63:0] digit_value(bit [7:0] c);
            if (c >= "0" && c <= "9") return c - "0";
            if (c >= "a" && c <= "f") return c - "a" + 10;
            if (c >= "A" && c <= "F") return c - "A" + 10;
            return 255;
        endfunction

        function bit fold_base60(output bit [63:0] res);
            res = '0;
            if (stotal > (MAG_LIMIT - sgroup) / 60) return 1'b0;
            res = stotal * 60 + sgroup;
            return 1'b1;
        endfunction

        function void radix_digit(bit [7:0] c);
            bit [63:0] r;
            bit [63:0] d;
            case (radix)
                RC_HEX:  r = 16;
                RC_OCT:  r = 8;
                RC_BIN:  r = 2;
                default: r = 10;
            endcase
            d = digit_value(c);
            if (d >= r) begin
                rfail = 1'b1;
                return;
            end
            if (phase == PH_WAIT) phase = PH_BODY;
            if (rfail) return;
            if (rmag > (MAG_LIMIT - d) / r) rfail = 1'b1;
            else rmag = rmag * r + d;
        endfunction

        function void base60_char(bit [7:0] c);
            bit [63:0] t;
            bit [63:0] d;
            if (sfail) return;
            if (c == ":") begin
                if (sdone >= 2 || (sdone > 0 && !gdigit) || !fold_base60(t)) begin
                    sfail = 1'b1;
                    return;
                end
                stotal = t;
                sgroup = '0;
                gdigit = 1'b0;
                sdone  = sdone + 2'd1;
            end else if (c >= "0" && c <= "9") begin
                d = c - "0";
                if (sgroup > (MAG_LIMIT - d) / 10) begin
                    sfail = 1'b1;
                    return;
                end
                sgroup = sgroup * 10 + d;
                gdigit = 1'b1;
            end else begin
                sfail = 1'b1;
            end
        endfunction

        function void body_char(bit [7:0] c);
            radix_digit(c);
            base60_char(c);
        endfunction

        // one accepted beat; the last beat of a scalar queues its parsed result
        function void note_char(bit [7:0] c, bit last);
            t_scalar_result res;
            bit             err;
            bit [63:0]      mag;
            bit [63:0]      lim;
            if (c != "_" && c != ",") begin
                if (kept <= SCAN_MAX_CHARS) kept++;
                if (c == ":") colon = 1'b1;
                case (phase)
                    PH_START, PH_SIGN: begin
                        if (phase == PH_START && c == "-") begin
                            neg   = 1'b1;
                            phase = PH_SIGN;
                        end else if (phase == PH_START && c == "+") begin
                            phase = PH_SIGN;
                        end else if (c == "0") begin
                            base60_char(c);
                            phase = PH_ZERO;
                        end else begin
                            phase = PH_BODY;
                            body_char(c);
                        end
                    end
                    PH_ZERO: begin
                        if (c == "x" || c == "X") begin
                            radix = RC_HEX;
                            phase = PH_WAIT;
                            sfail = 1'b1;
                        end else if (c == "b" || c == "B") begin
                            radix = RC_BIN;
                            phase = PH_WAIT;
                            sfail = 1'b1;
                        end else if (c == "o") begin
                            radix = RC_OCT;
                            phase = PH_BODY;
                        end else begin
                            radix = RC_OCT;
                            phase = PH_BODY;
                            body_char(c);
                        end
                    end
                    default: body_char(c);
                endcase
            end
            if (!last) return;
            err = kept > SCAN_MAX_CHARS;
            mag = '0;
            lim = neg ? MAG_LIMIT : MAG_LIMIT - 1;
            if (colon) begin
                if (sfail || !gdigit || !fold_base60(mag)) err = 1'b1;
            end else begin
                if (rfail || (phase != PH_ZERO && phase != PH_BODY)) err = 1'b1;
                mag = rmag;
            end
            if (mag > lim) err = 1'b1;
            res.error = err;
            res.value = err ? 64'sd0 : (neg ? -mag : mag);
            parsed_q.push_back(res);
            clear_scalar();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("mismatch: %s", msg);
        endfunction

        function void check_scalar(logic signed [63:0] v, logic e);
            t_scalar_result want;
            if (parsed_q.size() == 0) begin
                flag($sformatf("result with none pending: value %0d error %b", v, e));
                return;
            end
            want = parsed_q.pop_front();
            if (v !== want.value)
                flag($sformatf("value: expected %0d, got %0d", want.value, v));
            if (e !== want.error)
                flag($sformatf("error flag: expected %b, got %b", want.error, e));
        endfunction
    endclass

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               i_valid   = 1'b0;
    logic [7:0]         i_char_in = 8'h00;
    logic               i_is_last = 1'b0;
    logic               i_stall   = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic signed [63:0] o_value;
    logic               o_error;

    scalar_scoreboard sb = new();
    logic [7:0]       scalar_text[$];
    int               beats_sent = 0;
    bit               calm       = 1'b0;

    integer_literal_scanner_unit #(
        .MAX_CHARS(SCAN_MAX_CHARS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_char_in(i_char_in),
        .i_is_last(i_is_last),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_value  (o_value),
        .o_error  (o_error)
    );

    always #6 i_clk = ~i_clk;

    // result side: random stall, check every accepted result beat
    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        if (i_rst_n && o_valid === 1'b1 && !i_stall) sb.check_scalar(o_value, o_error);
    end

    task automatic send_beat(input logic [7:0] c, input logic last);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_char_in <= c;
        i_is_last <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_char(c, last);
        beats_sent++;
    endtask

    // separators may land anywhere, including as the last beat
    task automatic send_scalar();
        int n;
        bit trail;
        n     = scalar_text.size();
        trail = $urandom_range(0, 99) < 4;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 6) send_beat($urandom_range(0, 1) ? "_" : ",", 1'b0);
            send_beat(scalar_text[k], k == n - 1 && !trail);
        end
        if (trail) send_beat($urandom_range(0, 1) ? "_" : ",", 1'b1);
    endtask

    function automatic void add_str(string s);
        for (int k = 0; k < s.len(); k++) scalar_text.push_back(s[k]);
    endfunction

    function automatic logic [7:0] rand_digit(int base);
        int v;
        v = $urandom_range(0, base - 1);
        if (v < 10) return 8'("0" + v);
        return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
    endfunction

    function automatic void add_digits(int count, int base);
        for (int k = 0; k < count; k++) scalar_text.push_back(rand_digit(base));
    endfunction

    function automatic void add_sign();
        case ($urandom_range(0, 3))
            0: add_str("-");
            1: add_str("+");
            default: ;
        endcase
    endfunction

    function automatic int digit_count(int typical, int longest);
        if ($urandom_range(0, 9) == 0) return $urandom_range(1, longest);
        return $urandom_range(1, typical);
    endfunction

    function automatic void build_random();
        string      edges[10] = '{"9223372036854775807", "9223372036854775808",
                                  "-9223372036854775808", "-9223372036854775809",
                                  "0x7fffffffffffffff", "0x8000000000000000",
                                  "-0X8000000000000000", "0o777777777777777777777",
                                  "0", "-0"};
        string      junk = " \t+-.xgo:b";
        int         pick;
        int         groups;
        logic [7:0] bad;
        scalar_text.delete();
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            add_sign();
            add_digits(digit_count(6, 21), 10);
        end else if (pick < 32) begin
            add_sign();
            add_str($urandom_range(0, 1) ? "0x" : "0X");
            add_digits(digit_count(6, 18), 16);
        end else if (pick < 40) begin
            add_sign();
            add_str($urandom_range(0, 1) ? "0b" : "0B");
            add_digits(digit_count(10, 66), 2);
        end else if (pick < 48) begin
            add_sign();
            add_str($urandom_range(0, 1) ? "0o" : "0");
            add_digits(digit_count(6, 24), 8);
        end else if (pick < 62) begin
            add_sign();
            groups = $urandom_range(1, 3);
            if ($urandom_range(0, 4) != 0) add_digits(digit_count(3, 21), 10);
            for (int g = 0; g < groups; g++) begin
                add_str(":");
                if ($urandom_range(0, 19) != 0) add_digits(digit_count(2, 12), 10);
            end
        end else if (pick < 70) begin
            add_str(edges[$urandom_range(0, 9)]);
        end else if (pick < 75) begin
            // kept length around the limit
            repeat ($urandom_range(74, 82)) add_str("0");
            add_str("7");
        end else if (pick < 85) begin
            add_sign();
            add_digits(digit_count(5, 10), 10);
            bad = $urandom_range(0, 2) == 0 ? 8'($urandom_range(0, 255))
                                            : junk[$urandom_range(0, junk.len() - 1)];
            if ($urandom_range(0, 5) == 0) bad = 8'h00;
            scalar_text.insert($urandom_range(0, scalar_text.size()), bad);
        end else begin
            repeat ($urandom_range(1, 5)) begin
                if ($urandom_range(0, 1)) scalar_text.push_back(8'($urandom_range(0, 255)));
                else scalar_text.push_back(junk[$urandom_range(0, junk.len() - 1)]);
            end
        end
    endfunction

    initial begin
        string probes[9] = '{"-", "0x", "0o", "0b101", " 1", "+-1", ":30", "1:2:3:4",
                             "0x1:2"};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (probes[k]) begin
            scalar_text.delete();
            add_str(probes[k]);
            send_scalar();
        end
        scalar_text.delete();
        scalar_text.push_back(8'h00);
        send_scalar();
        while (beats_sent < BEAT_TARGET) begin
            calm = beats_sent >= 250 && beats_sent < 400;
            build_random();
            send_scalar();
        end
        calm = 1'b0;
        i_valid <= 1'b0;
        while (sb.parsed_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(12 * 200000);
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
design/ils_pkg.sv
design/ils_parse.sv
design/integer_literal_scanner_unit.sv
verif/integer_literal_scanner_unit_tb.sv
